>>> rtl/sequential_list_store_assert.svh
// assertion macros for the sequential list store
`ifndef SEQUENTIAL_LIST_STORE_ASSERT_SVH
`define SEQUENTIAL_LIST_STORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SLS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SLS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sls_pkg.sv
// shared constants and types for the sequential list store
package sls_pkg;

   localparam int DEPTH = 128;
   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (LEN_W > 8) ? LEN_W : 8;
   localparam int DATA_W = 32;
   localparam int POS_W = 8;
   localparam int OP_W = 3;
   localparam int ST_W = 2;

   localparam logic [OP_W-1:0] OP_GET    = 3'd0;
   localparam logic [OP_W-1:0] OP_LOCATE = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic              shift_up;
      logic              shift_down;
      logic              locate;
      logic [IDX_W-1:0]  slot;
      logic [DATA_W-1:0] value;
      logic [LEN_W-1:0]  length;
   } cmd_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] data;
      logic [IDX_W-1:0]  slot;
   } tok_type;

endpackage

>>> rtl/sls_cell.sv
// one list entry: holds a value, shifts with its neighbors, passes the search token on
module sls_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  sls_pkg::cmd_type           cmd,
   input  logic [sls_pkg::IDX_W-1:0]  cell_index,
   input  logic [sls_pkg::DATA_W-1:0] left_data,
   input  logic [sls_pkg::DATA_W-1:0] right_data,
   input  sls_pkg::tok_type           tok_prev,
   output logic [sls_pkg::DATA_W-1:0] data_out,
   output sls_pkg::tok_type           tok_next
);

   logic [sls_pkg::DATA_W-1:0] data_ff;
   logic [sls_pkg::DATA_W-1:0] data_in;
   sls_pkg::tok_type           tok_ff;
   sls_pkg::tok_type           tok_in;
   logic                       match;

   always_comb begin
      if (cmd.shift_up && (cell_index > cmd.slot)) begin
         data_in = left_data;
      end else if (cmd.shift_up && (cell_index == cmd.slot)) begin
         data_in = cmd.value;
      end else if (cmd.shift_down && (cell_index >= cmd.slot)) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_comb begin
      if (cmd.locate) begin
         match = (data_ff == cmd.value) && (sls_pkg::LEN_W'(cell_index) < cmd.length);
      end else begin
         match = (cell_index == cmd.slot);
      end
      if (tok_prev.hit) begin
         tok_in = tok_prev;
      end else if (match) begin
         tok_in.hit  = 1'b1;
         tok_in.data = data_ff;
         tok_in.slot = cell_index;
      end else begin
         tok_in = tok_prev;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign data_out = data_ff;
   assign tok_next = tok_ff;

endmodule

>>> rtl/sequential_list_store.sv
// top level of the sequential list store: request decode, length tracking, cell chain
//
// The list lives in a chain of DEPTH cells, one entry per cell. One request is
// handled at a time. Its response moves into an output register, so the next
// request can be accepted while that response waits to be taken; a finished
// request waits in place while an earlier response still sits in the register.
// Insert, clear, unused op codes and any request that fails its position or
// full check go straight to the response state with no sweep; an insert moves
// all later entries up one cell in a single shift. Get, locate and delete send
// a search token down the cell chain one cell per cycle, and their response is
// ready once the token has passed the last cell; a delete shifts the later
// entries down one cell after the sweep, while it waits in the response state.
// A new request is accepted only once the previous one has moved its response
// into the output register. No clearing pass is needed after reset.
`include "sequential_list_store_assert.svh"

module sequential_list_store (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[7:0], value_in[39:8]
   input  logic [2:0]  req_tuser,   // op[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // value_out[31:0], found_index[39:32], count[47:40]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;

   state_type                         state_ff, state_in;
   logic [sls_pkg::LEN_W-1:0]         length_ff, length_in;
   logic [sls_pkg::LEN_W-1:0]         cnt_ff, cnt_in;
   logic                              shift_up_ff, shift_up_in;
   logic                              shift_down_ff, shift_down_in;
   logic                              locate_ff, locate_in;
   logic                              delete_ff, delete_in;
   logic [sls_pkg::IDX_W-1:0]         slot_ff, slot_in;
   logic [sls_pkg::DATA_W-1:0]        value_ff, value_in;
   logic [sls_pkg::ST_W-1:0]          status_ff, status_in;
   logic [sls_pkg::DATA_W-1:0]        vout_ff, vout_in;
   logic [7:0]                        found_ff, found_in;

   logic                              out_valid_ff, out_valid_in;
   logic [sls_pkg::ST_W-1:0]          out_status_ff, out_status_in;
   logic [sls_pkg::DATA_W-1:0]        out_vout_ff, out_vout_in;
   logic [7:0]                        out_found_ff, out_found_in;
   logic [sls_pkg::LEN_W-1:0]         out_len_ff, out_len_in;

   logic [sls_pkg::CMP_W-1:0]         pos_w;
   logic [sls_pkg::CMP_W-1:0]         len_w;
   logic [sls_pkg::CMP_W-1:0]         out_len_w;
   logic [sls_pkg::CMP_W-1:0]         pos_m1;
   logic [sls_pkg::CMP_W-1:0]         found_w;
   logic                              rd_ok;
   logic                              ins_ok;
   logic [sls_pkg::OP_W-1:0]          op;

   logic [sls_pkg::LEN_W-1:0]         depth_len;
   logic                              shifting;
   logic                              shift_ok;
   logic                              full_rsp;
   logic                              scan_busy;

   sls_pkg::cmd_type                  cmd;
   logic [sls_pkg::DATA_W-1:0]        cell_data [sls_pkg::DEPTH];
   sls_pkg::tok_type                  cell_tok  [sls_pkg::DEPTH];
   sls_pkg::tok_type                  last_tok;

   assign op     = req_tuser;
   assign pos_w  = sls_pkg::CMP_W'(req_tdata[7:0]);
   assign len_w  = sls_pkg::CMP_W'(length_ff);
   assign pos_m1 = pos_w - sls_pkg::CMP_W'(1);
   assign rd_ok  = (pos_w != '0) && (pos_w <= len_w);
   assign ins_ok = (pos_w != '0) && (pos_w <= len_w + sls_pkg::CMP_W'(1));

   assign last_tok = cell_tok[sls_pkg::DEPTH-1];
   assign found_w  = sls_pkg::CMP_W'(last_tok.slot) + sls_pkg::CMP_W'(1);

   always_comb begin
      state_in      = state_ff;
      length_in     = length_ff;
      cnt_in        = cnt_ff;
      shift_up_in   = 1'b0;
      shift_down_in = 1'b0;
      locate_in     = locate_ff;
      delete_in     = delete_ff;
      slot_in       = slot_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      vout_in       = vout_ff;
      found_in      = found_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_vout_in   = out_vout_ff;
      out_found_in  = out_found_ff;
      out_len_in    = out_len_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               slot_in   = pos_m1[sls_pkg::IDX_W-1:0];
               value_in  = req_tdata[39:8];
               locate_in = 1'b0;
               delete_in = 1'b0;
               cnt_in    = '0;
               status_in = sls_pkg::ST_OK;
               vout_in   = '0;
               found_in  = '0;
               state_in  = S_RESP;
               case (op)
                  sls_pkg::OP_GET: begin
                     if (rd_ok) begin
                        state_in = S_SCAN;
                     end else begin
                        status_in = sls_pkg::ST_RANGE;
                     end
                  end
                  sls_pkg::OP_LOCATE: begin
                     locate_in = 1'b1;
                     state_in  = S_SCAN;
                  end
                  sls_pkg::OP_INSERT: begin
                     if (!ins_ok) begin
                        status_in = sls_pkg::ST_RANGE;
                     end else if (length_ff == sls_pkg::LEN_W'(sls_pkg::DEPTH)) begin
                        status_in = sls_pkg::ST_FULL;
                     end else begin
                        shift_up_in = 1'b1;
                        length_in   = length_ff + sls_pkg::LEN_W'(1);
                     end
                  end
                  sls_pkg::OP_DELETE: begin
                     if (rd_ok) begin
                        delete_in = 1'b1;
                        state_in  = S_SCAN;
                     end else begin
                        status_in = sls_pkg::ST_RANGE;
                     end
                  end
                  sls_pkg::OP_CLEAR: begin
                     length_in = '0;
                  end
                  default: begin
                     status_in = sls_pkg::ST_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + sls_pkg::LEN_W'(1);
            if (cnt_ff == sls_pkg::LEN_W'(sls_pkg::DEPTH)) begin
               state_in = S_RESP;
               if (locate_ff) begin
                  found_in = last_tok.hit ? found_w[7:0] : 8'd0;
               end else begin
                  vout_in = last_tok.data;
               end
               if (delete_ff) begin
                  shift_down_in = 1'b1;
                  length_in     = length_ff - sls_pkg::LEN_W'(1);
               end
            end
         end
         S_RESP: begin
            if (!out_valid_ff || rsp_tready) begin
               state_in      = S_IDLE;
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_vout_in   = vout_ff;
               out_found_in  = found_ff;
               out_len_in    = length_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         length_ff     <= '0;
         cnt_ff        <= '0;
         shift_up_ff   <= 1'b0;
         shift_down_ff <= 1'b0;
         locate_ff     <= 1'b0;
         delete_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         length_ff     <= length_in;
         cnt_ff        <= cnt_in;
         shift_up_ff   <= shift_up_in;
         shift_down_ff <= shift_down_in;
         locate_ff     <= locate_in;
         delete_ff     <= delete_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      vout_ff       <= vout_in;
      found_ff      <= found_in;
      out_status_ff <= out_status_in;
      out_vout_ff   <= out_vout_in;
      out_found_ff  <= out_found_in;
      out_len_ff    <= out_len_in;
   end

   assign cmd.shift_up   = shift_up_ff;
   assign cmd.shift_down = shift_down_ff;
   assign cmd.locate     = locate_ff;
   assign cmd.slot       = slot_ff;
   assign cmd.value      = value_ff;
   assign cmd.length     = length_ff;

   for (genvar i = 0; i < sls_pkg::DEPTH; i++) begin : g_cell
      logic [sls_pkg::DATA_W-1:0] left_data;
      logic [sls_pkg::DATA_W-1:0] right_data;
      sls_pkg::tok_type           tok_prev;

      if (i == 0) begin : g_first
         assign left_data = '0;
         assign tok_prev  = '0;
      end else begin : g_inner
         assign left_data = cell_data[i-1];
         assign tok_prev  = cell_tok[i-1];
      end

      if (i == sls_pkg::DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_body
         assign right_data = cell_data[i+1];
      end

      sls_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .cell_index (sls_pkg::IDX_W'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .tok_prev   (tok_prev),
         .data_out   (cell_data[i]),
         .tok_next   (cell_tok[i])
      );
   end

   assign out_len_w  = sls_pkg::CMP_W'(out_len_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {out_len_w[7:0], out_found_ff, out_vout_ff};

   assign depth_len = sls_pkg::LEN_W'(sls_pkg::DEPTH);
   assign shifting  = shift_up_ff || shift_down_ff;
   assign shift_ok  = !(shift_up_ff && shift_down_ff) && (state_ff == S_RESP);
   assign full_rsp  = rsp_tvalid && (out_status_ff == sls_pkg::ST_FULL);
   assign scan_busy = (state_ff == S_SCAN) && (cnt_ff != depth_len);

   `SLS_ASSERT_NOW(a_len_max, 1'b1, length_ff <= depth_len, "length above depth")
   `SLS_ASSERT_NOW(a_shift_excl, shifting, shift_ok, "shift outside response or both ways")
   `SLS_ASSERT_NOW(a_full_status, full_rsp, out_len_ff == depth_len, "full status with room left")
   `SLS_ASSERT_NEXT(a_scan_hold, scan_busy, $stable(cmd), "scan inputs moved during sweep")

endmodule

>>> bench/list_store_checker.sv
// checker for the sequential list store: tracks the list, predicts each response and compares it
module list_store_checker
   import sls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // position[7:0], value_in[39:8]
   input  logic [2:0]  req_tuser,   // op[2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // value_out[31:0], found_index[39:32], count[47:40]
   input  logic [1:0]  rsp_tuser,   // status[1:0]
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ST_W-1:0] status;
      logic [31:0]     value_out;
      logic [7:0]      found_index;
      logic [7:0]      count;
   } list_result_t;

   logic [31:0]  shadow_list[$];
   list_result_t awaited_results[$];

   initial begin
      failures = 0;
      pending = 0;
   end

   function automatic list_result_t apply_list_request(input logic [2:0] op,
                                                       input logic [7:0] pos,
                                                       input logic [31:0] value);
      list_result_t res;
      int len;
      int p;
      res = '0;
      len = shadow_list.size();
      p = pos;
      case (op)
         OP_GET: begin
            if (p < 1 || p > len) res.status = ST_RANGE;
            else res.value_out = shadow_list[p-1];
         end
         OP_LOCATE: begin
            for (int k = 0; k < len; k++) begin
               if (shadow_list[k] == value) begin
                  res.found_index = 8'(k + 1);
                  break;
               end
            end
         end
         OP_INSERT: begin
            if (p < 1 || p > len + 1) res.status = ST_RANGE;
            else if (len >= DEPTH) res.status = ST_FULL;
            else shadow_list.insert(p - 1, value);
         end
         OP_DELETE: begin
            if (p < 1 || p > len) begin
               res.status = ST_RANGE;
            end else begin
               res.value_out = shadow_list[p-1];
               shadow_list.delete(p - 1);
            end
         end
         OP_CLEAR: shadow_list.delete();
         default: ;
      endcase
      res.count = 8'(shadow_list.size());
      return res;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : monitor
      list_result_t want;
      list_result_t got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[39:32], rsp_tdata[47:40]};
            if (awaited_results.size() == 0) begin
               $error("response beat with no request outstanding");
               failures++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", want.status, got.status);
               check_field("value_out", $signed(want.value_out), $signed(got.value_out));
               check_field("found_index", want.found_index, got.found_index);
               check_field("count", want.count, got.count);
            end
         end
         if (req_tvalid && req_tready)
            awaited_results.push_back(apply_list_request(req_tuser, req_tdata[7:0],
                                                         req_tdata[39:8]));
      end
      pending = awaited_results.size();
   end

endmodule

>>> bench/tb.sv
// top of the sequential list store bench: clock, reset, request stimulus, response pacing, verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sls_pkg::*;

   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;
   localparam int MAX_GAP = 20;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = DEPTH + 12;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RECENT_N = 16;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // position[7:0], value_in[39:8]
   logic [2:0]  req_tuser;   // op[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // value_out[31:0], found_index[39:32], count[47:40]
   logic [1:0]  rsp_tuser;   // status[1:0]

   int failures;
   int pending;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_asked;
   int hold_taken;
   int hold_left;
   int stuck_cycles;
   int list_len;
   int recent_wr;
   logic [31:0] recent[RECENT_N];

   sequential_list_store i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   list_store_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .failures   (failures),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // response side: random back-pressure plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_asked) begin
         hold_taken <= hold_asked;
         hold_left <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic offer_request(input logic [2:0] op, input logic [7:0] pos,
                                input logic [31:0] value);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {value, pos};
      do @(posedge clock); while (!req_tready);
      // length bookkeeping and recent inserted values, to steer positions and values
      case (op)
         OP_INSERT: begin
            if (pos >= 1 && pos <= list_len + 1 && list_len < DEPTH) list_len++;
            recent[recent_wr] = value;
            recent_wr = (recent_wr + 1) % RECENT_N;
         end
         OP_DELETE: if (pos >= 1 && pos <= list_len) list_len--;
         OP_CLEAR: list_len = 0;
         default: ;
      endcase
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 8) return 32'h8000_0000;
      if (sel < 16) return 32'h7fff_ffff;
      if (sel < 24) return 32'(sel % 3) - 32'd1;
      if (sel < 45) return recent[$urandom_range(RECENT_N - 1)];
      return $urandom;
   endfunction

   function automatic logic [7:0] pick_position(input logic [2:0] op);
      int top_pos;
      top_pos = (op == OP_INSERT) ? list_len + 1 : list_len;
      if (top_pos == 0 || $urandom_range(99) < 12) return 8'($urandom_range(255));
      case ($urandom_range(3))
         0: return 8'd1;
         1: return 8'(top_pos);
         default: return 8'($urandom_range(top_pos, 1));
      endcase
   endfunction

   task automatic random_request(input int insert_pct);
      int sel;
      logic [2:0] op;
      sel = $urandom_range(99);
      if (sel < insert_pct) begin
         op = OP_INSERT;
      end else begin
         sel = $urandom_range(99);
         if (sel < 30) op = OP_GET;
         else if (sel < 55) op = OP_LOCATE;
         else if (sel < 90) op = OP_DELETE;
         else if (sel < 94) op = OP_CLEAR;
         else op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end
      offer_request(op, pick_position(op), pick_value());
   endtask

   // set the pacing and ask for a hold-off, fill to full, poke at the full list, then churn
   task automatic run_phase(input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      hold_asked <= hold_asked + 1;
      while (list_len < DEPTH) random_request(100);
      repeat (8) random_request(50);
      repeat (50) random_request(25);
      settle();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      send_idle_pct = 7;
      recv_idle_pct = 48;
      hold_asked = 0;
      hold_taken = 0;
      hold_left = 0;
      stuck_cycles = 0;
      list_len = 0;
      recent_wr = 0;
      foreach (recent[i]) recent[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty list corner cases
      offer_request(OP_GET, 8'd1, 32'd0);
      offer_request(OP_DELETE, 8'd0, 32'd0);
      offer_request(OP_LOCATE, 8'd0, 32'd0);
      offer_request(OP_INSERT, 8'd0, 32'd5);
      offer_request(OP_INSERT, 8'd2, 32'd5);
      // extremes and duplicates, then lookups, deletes, out-of-range positions, unused op codes and clear
      offer_request(OP_INSERT, 8'd1, 32'h8000_0000);
      offer_request(OP_INSERT, 8'd2, 32'h7fff_ffff);
      offer_request(OP_INSERT, 8'd1, 32'hffff_ffff);
      offer_request(OP_INSERT, 8'd2, 32'hffff_ffff);
      offer_request(OP_LOCATE, 8'd0, 32'hffff_ffff);
      offer_request(OP_LOCATE, 8'd255, 32'h7fff_ffff);
      offer_request(OP_LOCATE, 8'd3, 32'd12345);
      offer_request(OP_GET, 8'd4, 32'd0);
      offer_request(OP_GET, 8'd5, 32'd0);
      offer_request(OP_GET, 8'd255, 32'hffff_ffff);
      offer_request(OP_DELETE, 8'd4, 32'd0);
      offer_request(OP_DELETE, 8'd1, 32'd0);
      offer_request(OP_INSERT, 8'd255, 32'h5a5a_a5a5);
      for (int u = OP_UNUSED_LO; u <= OP_UNUSED_HI; u++)
         offer_request(3'(u), 8'd1, 32'd1);
      offer_request(OP_CLEAR, 8'd0, 32'd0);
      offer_request(OP_GET, 8'd1, 32'd0);
      offer_request(OP_INSERT, 8'd1, 32'd0);
      settle();

      run_phase(7, 48);
      run_phase(48, 7);
      run_phase(0, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/sls_pkg.sv
rtl/sls_cell.sv
rtl/sequential_list_store.sv
bench/list_store_checker.sv
bench/tb.sv
